// ===== hw/rtl/tdf_pkg.sv =====
// Shared constants and types for the trial-division factorizer.
// No dependencies; imported by tdf_divider and trial_division_factorizer.
package tdf_pkg;

  // Width of the value that is factored (low bits of the input beat)
  localparam int VALUE_BITS  = 32;
  // Fixed field widths on the ports
  localparam int NUMBER_W    = 32;
  localparam int FACTOR_W    = 32;
  // Result beats per input are capped at this count
  localparam int MAX_RESULTS = 32;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS);
  // Divider step counter holds VALUE_BITS down to 0
  localparam int DIV_CNT_W   = $clog2(VALUE_BITS + 1);

  typedef logic [VALUE_BITS-1:0] value_t;

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

endpackage

// ===== hw/rtl/trial_division_factorizer.sv =====
// Trial-division prime factorizer, top level.
// Depends on tdf_pkg and tdf_divider.

// One input beat carries a number; the block emits its prime factors in
// nondecreasing order, repeats included, one output beat each, with last set
// on the final one. Inputs 0 and 1 give one beat with no_factor = 1, factor 0.
// The block works on one number at a time and holds in_stall high until the
// final beat has been handed to the output register. Each trial division runs
// on one shared radix-2 divider; an item costs roughly (number of trial divisors
// + number of factors) divisions. The divisor walks 2, then the odd numbers from
// 3 up to sqrt of the remainder, so a 32-bit prime needs about 32768 trials,
// and no 32-bit input takes longer than a prime just below 2^32, output stalls
// aside. No clearing pass after reset.
module trial_division_factorizer
  import tdf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [NUMBER_W-1:0] number,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [FACTOR_W-1:0] factor,
  output logic                no_factor,
  output logic                last
);

  logic [1:0]           state;
  value_t               rem;
  value_t               d;
  logic [RES_CNT_W-1:0] cnt;
  value_t               pend_factor;
  logic                 pend_none;
  logic                 pend_last;
  logic                 in_take;
  logic                 out_free;
  logic                 div_start;
  logic                 div_done;
  value_t               div_q;
  value_t               div_r;
  value_t               num_val;

  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign div_start = (state == S_LOAD);
  assign num_val   = VALUE_BITS'(number);

  tdf_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (rem),
    .divisor   (d),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Sequencer: divide, decide, emit
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            cnt <= '0;
            if (num_val < VALUE_BITS'(2)) begin
              state <= S_EMIT;
            end else begin
              state <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            // divisor past sqrt: remainder is prime; exact hit: emit divisor
            if (d > div_q || div_r == '0) begin
              state <= S_EMIT;
            end else begin
              state <= S_LOAD;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            cnt   <= cnt + RES_CNT_W'(1);
            state <= pend_last ? S_IDLE : S_LOAD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Working registers: remainder, trial divisor, pending result
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_take) begin
      rem         <= num_val;
      d           <= VALUE_BITS'(2);
      pend_factor <= '0;
      pend_none   <= 1'b1;
      pend_last   <= 1'b1;
    end else if (state == S_WAIT && div_done) begin
      pend_none <= 1'b0;
      if (d > div_q) begin
        pend_factor <= rem;
        pend_last   <= 1'b1;
      end else if (div_r == '0) begin
        pend_factor <= d;
        rem         <= div_q;
        pend_last   <= (div_q == VALUE_BITS'(1)) ||
                       (cnt == RES_CNT_W'(MAX_RESULTS - 1));
      end else begin
        d <= (d == VALUE_BITS'(2)) ? VALUE_BITS'(3) : d + VALUE_BITS'(2);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      factor    <= FACTOR_W'(pend_factor);
      no_factor <= pend_none;
      last      <= pend_last;
    end
  end

  // Divider only finishes while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_WAIT)
    else $error("divider done outside wait state");

  // A no-factor beat is always the only one and carries zero
  a_none_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_factor |-> last && factor == '0)
    else $error("no_factor beat without last or with nonzero factor");

  // Trial divisor and remainder are at least two whenever a division is launched
  a_div_ge2: assert property (@(posedge clk) disable iff (rst)
    div_start |-> d >= VALUE_BITS'(2) && rem >= VALUE_BITS'(2))
    else $error("division launched with bad operands");

  // An accepted beat goes straight to a division or to the single result
  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    in_take |=> state == S_LOAD || state == S_EMIT)
    else $error("unexpected state after accept");

endmodule

// ===== hw/rtl/tdf_divider.sv =====
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Depends on tdf_pkg (value_t, VALUE_BITS, DIV_CNT_W).
module tdf_divider
  import tdf_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  value_t dividend,
  input  value_t divisor,
  output logic   done,
  output value_t quotient,
  output value_t remainder
);

  logic [DIV_CNT_W-1:0] cnt;
  value_t               acc;
  value_t               quo;
  value_t               dsr;
  logic [VALUE_BITS:0]  shifted;
  logic [VALUE_BITS:0]  diff;
  logic                 fits;

  // One shift-subtract step
  always_comb begin
    shifted = {acc, quo[VALUE_BITS-1]};
    diff    = shifted - {1'b0, dsr};
    fits    = (shifted >= {1'b0, dsr});
  end

  // Step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= DIV_CNT_W'(VALUE_BITS);
      end else if (cnt != '0) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (cnt != '0) begin
      acc <= fits ? diff[VALUE_BITS-1:0] : shifted[VALUE_BITS-1:0];
      quo <= {quo[VALUE_BITS-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign remainder = acc;

endmodule

// ===== verif/trial_division_factorizer_test.sv =====
// Self-checking testbench for trial_division_factorizer: a directed table of numbers, then
// random numbers, each checked beat by beat against the table or a behavioral factorizer.
// Depends on tdf_pkg and the trial_division_factorizer RTL.
module trial_division_factorizer_test;
  import tdf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIRECTED_N = 21;
  localparam int RANDOM_N   = 80;

  // One expected output beat, tagged with the number that caused it
  typedef struct {
    logic [NUMBER_W-1:0] number;
    logic [FACTOR_W-1:0] factor;
    logic                no_factor;
    logic                last;
  } factor_beat_t;

  // Directed row: known rows give the single beat outright, others go to the predictor
  typedef struct packed {
    logic [NUMBER_W-1:0] number;
    logic                known;
    logic [FACTOR_W-1:0] factor;
    logic                no_factor;
  } directed_row_t;

  directed_row_t directed_rows [DIRECTED_N] = '{
    '{32'd0,          1'b1, 32'd0,     1'b1},  // zero: no factor
    '{32'd1,          1'b1, 32'd0,     1'b1},  // one: no factor
    '{32'd2,          1'b1, 32'd2,     1'b0},  // smallest prime
    '{32'd3,          1'b1, 32'd3,     1'b0},
    '{32'd4,          1'b0, 32'd0,     1'b0},  // final factor 2
    '{32'd6,          1'b0, 32'd0,     1'b0},
    '{32'd8,          1'b0, 32'd0,     1'b0},
    '{32'd9,          1'b0, 32'd0,     1'b0},
    '{32'd12,         1'b0, 32'd0,     1'b0},
    '{32'd97,         1'b1, 32'd97,    1'b0},
    '{32'd4093,       1'b1, 32'd4093,  1'b0},
    '{32'd65521,      1'b1, 32'd65521, 1'b0},  // largest 16-bit prime
    '{32'd131042,     1'b0, 32'd0,     1'b0},  // 2 times a large prime
    '{32'd63001,      1'b0, 32'd0,     1'b0},  // square of a prime
    '{32'd1005973,    1'b0, 32'd0,     1'b0},  // two primes near 1000
    '{32'd30030,      1'b0, 32'd0,     1'b0},  // six distinct primes
    '{32'h8000_0000,  1'b0, 32'd0,     1'b0},  // most beats: 31 twos
    '{32'hFFFF_FFFF,  1'b0, 32'd0,     1'b0},  // all ones
    '{32'hAAAA_AAAA,  1'b0, 32'd0,     1'b0},
    '{32'h5555_5555,  1'b0, 32'd0,     1'b0},
    '{32'hFFFF_0000,  1'b0, 32'd0,     1'b0}
  };

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [NUMBER_W-1:0] number    = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [FACTOR_W-1:0] factor;
  logic                no_factor;
  logic                last;

  factor_beat_t pending_factors [$];
  int  mismatches    = 0;
  int  beats_checked = 0;
  int  numbers_sent  = 0;
  int  stall_pct     = 30;
  bit  idle_on       = 1'b1;
  int  stall_run     = 0;

  trial_division_factorizer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .number    (number),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .factor    (factor),
    .no_factor (no_factor),
    .last      (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Ends a hung run; normal runs finish far below this
  initial begin
    #80_000_000;
    $display("trial_division_factorizer test failed");
    $finish;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Behavioral factorizer: queues the beats expected for one number
  function automatic void predict_factors(input logic [NUMBER_W-1:0] n);
    value_t       rem;
    value_t       divisor;
    value_t       found [$];
    int           count;
    factor_beat_t beat;
    rem = value_t'(n);
    beat.number = n;
    if (rem < 2) begin
      beat.factor    = '0;
      beat.no_factor = 1'b1;
      beat.last      = 1'b1;
      pending_factors = {pending_factors, beat};
      return;
    end
    divisor = 2;
    while (divisor <= rem / divisor) begin
      while (rem % divisor == 0) begin
        found = {found, divisor};
        rem = rem / divisor;
      end
      divisor = (divisor == 2) ? value_t'(3) : divisor + 2;
    end
    // leftover above one is itself prime
    if (rem > 1) found = {found, rem};
    count = (found.size() > MAX_RESULTS) ? MAX_RESULTS : found.size();
    for (int i = 0; i < count; i++) begin
      beat.factor    = FACTOR_W'(found[i]);
      beat.no_factor = 1'b0;
      beat.last      = (i == count - 1);
      pending_factors = {pending_factors, beat};
    end
  endfunction

  // Random numbers kept cheap to factor: small values, smooth composites,
  // and small values shifted into the top bits
  function automatic logic [NUMBER_W-1:0] random_number();
    logic [63:0] prod;
    int unsigned f;
    prod = 64'd1;
    case ($urandom_range(0, 9)) inside
      [0:3]: return $urandom_range(0, 65535);
      [4:6]: begin
        for (int k = 0; k < 40; k++) begin
          f = $urandom_range(2, 200);
          if (prod * f > 64'hFFFF_FFFF) break;
          prod = prod * f;
        end
        return prod[NUMBER_W-1:0];
      end
      [7:8]: return $urandom_range(0, 1 << 20);
      default: return NUMBER_W'($urandom_range(1, 4095)) << $urandom_range(20, 31);
    endcase
  endfunction

  // Send one number; the beat is predicted once it is sure to be taken
  task automatic send_number(input logic [NUMBER_W-1:0] n, input bit known,
                             input logic [FACTOR_W-1:0] kfactor, input logic knone);
    int           gap;
    factor_beat_t beat;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    number   <= n;
    do @(negedge clk); while (in_stall);
    if (known) begin
      beat.number    = n;
      beat.factor    = kfactor;
      beat.no_factor = knone;
      beat.last      = 1'b1;
      pending_factors = {pending_factors, beat};
    end else begin
      predict_factors(n);
    end
    numbers_sent++;
    @(posedge clk);
  endtask

  // Hold the input side until every queued factor beat is out
  task automatic drain_factors();
    in_valid <= 1'b0;
    while (pending_factors.size() != 0) @(posedge clk);
  endtask

  // Output stall: random runs, switched off in full-rate stretches
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run != 0) begin
      out_stall <= 1'b1;
      stall_run <= stall_run - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_run <= pick_gap();
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check each factor beat before the edge that takes it; inputs and
  // outputs are settled at the falling edge
  always @(negedge clk) begin : check_beats
    factor_beat_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      beats_checked++;
      if (pending_factors.size() == 0) begin
        $display("%0t ns: unexpected beat: factor %0d no_factor %0b last %0b",
                 $time, factor, no_factor, last);
        mismatches++;
      end else begin
        want = pending_factors.pop_front();
        if (factor !== want.factor) begin
          $display("%0t ns: factor of %0d: expected %0d, actual %0d",
                   $time, want.number, want.factor, factor);
          mismatches++;
        end
        if (no_factor !== want.no_factor) begin
          $display("%0t ns: no_factor of %0d: expected %0b, actual %0b",
                   $time, want.number, want.no_factor, no_factor);
          mismatches++;
        end
        if (last !== want.last) begin
          $display("%0t ns: last of %0d: expected %0b, actual %0b",
                   $time, want.number, want.last, last);
          mismatches++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, random part, drain
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_number(directed_rows[i].number, directed_rows[i].known,
                  directed_rows[i].factor, directed_rows[i].no_factor);
    drain_factors();

    for (int i = 0; i < RANDOM_N; i++) begin
      // alternate idling and full-rate stretches
      if (i % 25 == 0) begin
        idle_on   = (i % 50 == 0);
        stall_pct = idle_on ? 30 : 0;
      end
      if (i == RANDOM_N / 2) drain_factors();
      send_number(random_number(), 1'b0, '0, 1'b0);
    end
    in_valid <= 1'b0;

    while (pending_factors.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Factored %0d numbers (%0d directed), checked %0d factor beats, %0d mismatches.",
             numbers_sent, DIRECTED_N, beats_checked, mismatches);
    if (mismatches == 0 && pending_factors.size() == 0)
      $display("trial_division_factorizer test passed");
    else
      $display("trial_division_factorizer test failed");
    $finish;
  end

endmodule
